@@ rtl/core/crc32c_combine_macros.svh @@
// ----------------------------------------------------------------------------
// crc32c_combine_macros.svh
// Assertion macros for the CRC-32C combine block.
// ----------------------------------------------------------------------------
`ifndef CRC32C_COMBINE_MACROS_SVH
`define CRC32C_COMBINE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Implication checked on every rising edge outside reset.
`define CRC32C_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define CRC32C_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CRC32C_ASSERT(label, clk, rst, prop, msg)
`define CRC32C_NEVER(label, clk, rst, cond, msg)
`endif

`endif

@@ rtl/core/crc32c_pkg.sv @@
// ----------------------------------------------------------------------------
// crc32c_pkg
// Types, constants and GF(2) matrix helpers for the CRC-32C combine block.
// ----------------------------------------------------------------------------
package crc32c_pkg;

  localparam int unsigned CrcW    = 32;
  localparam int unsigned LenBits = 32;
  localparam int unsigned IdxW    = $clog2(LenBits);
  localparam logic [CrcW-1:0] Poly = 32'h82F6_3B78;

  // Column b of a matrix is the image of bit b.
  typedef logic [CrcW-1:0][CrcW-1:0]              mat_t;
  typedef logic [LenBits-1:0][CrcW-1:0][CrcW-1:0] tab_t;

  typedef struct packed {
    logic            load;
    logic            step;
    logic [IdxW-1:0] idx;
  } dp_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  function automatic logic [CrcW-1:0] mat_apply(mat_t m, logic [CrcW-1:0] v);
    logic [CrcW-1:0] acc;
    acc = '0;
    for (int b = 0; b < CrcW; b++) begin
      if (v[b]) acc = acc ^ m[b];
    end
    return acc;
  endfunction

  function automatic mat_t mat_square(mat_t m);
    mat_t t;
    for (int b = 0; b < CrcW; b++) begin
      t[b] = mat_apply(m, m[b]);
    end
    return t;
  endfunction

  // Operators for 2^k zero bytes, k = 0 .. LenBits-1; evaluated at elaboration.
  function automatic tab_t build_table();
    mat_t op;
    tab_t t;
    op[0] = Poly;
    for (int k = 1; k < CrcW; k++) begin
      op[k] = CrcW'(1) << (k - 1);
    end
    op = mat_square(op);
    op = mat_square(op);
    op = mat_square(op);
    for (int k = 0; k < LenBits; k++) begin
      t[k] = op;
      op = mat_square(op);
    end
    return t;
  endfunction

  localparam tab_t OpTable = build_table();

endpackage

@@ rtl/core/crc32c_ctrl.sv @@
// ----------------------------------------------------------------------------
// crc32c_ctrl
// Sequencer: accepts a transfer, walks the length bits, strobes the result.
// ----------------------------------------------------------------------------
module crc32c_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  output crc32c_pkg::dp_cmd_t  cmd
);

  crc32c_pkg::state_t              state, state_next;
  logic [crc32c_pkg::IdxW-1:0]     cnt, cnt_next;
  logic                            accept;
  logic                            last;

  assign busy   = (state == crc32c_pkg::S_RUN);
  assign done   = (state == crc32c_pkg::S_DONE);
  assign accept = start && !busy;
  assign last   = (cnt == crc32c_pkg::IdxW'(crc32c_pkg::LenBits - 1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.idx    = cnt;
    unique case (state)
      crc32c_pkg::S_IDLE, crc32c_pkg::S_DONE: begin
        state_next = crc32c_pkg::S_IDLE;
        if (accept) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = crc32c_pkg::S_RUN;
        end
      end
      crc32c_pkg::S_RUN: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (last) state_next = crc32c_pkg::S_DONE;
      end
      default: state_next = crc32c_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crc32c_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ rtl/core/crc32c_dpath.sv @@
// ----------------------------------------------------------------------------
// crc32c_dpath
// Operand registers and the shared 32x32 GF(2) matrix-vector unit.
// ----------------------------------------------------------------------------
module crc32c_dpath (
  input  logic                             clk,
  input  crc32c_pkg::dp_cmd_t              cmd,
  input  logic [crc32c_pkg::CrcW-1:0]      crc_first,
  input  logic [crc32c_pkg::CrcW-1:0]      crc_second,
  input  logic [crc32c_pkg::LenBits-1:0]   second_length,
  output logic [crc32c_pkg::CrcW-1:0]      crc_joined
);

  logic [crc32c_pkg::CrcW-1:0]    crc;
  logic [crc32c_pkg::CrcW-1:0]    crc2;
  logic [crc32c_pkg::LenBits-1:0] len;
  logic                           len_zero;
  logic [crc32c_pkg::CrcW-1:0]    crc_adv;

  assign crc_adv = crc32c_pkg::mat_apply(crc32c_pkg::OpTable[cmd.idx], crc);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      crc      <= crc_first;
      crc2     <= crc_second;
      len      <= second_length;
      len_zero <= (second_length == '0);
    end else if (cmd.step) begin
      if (len[0]) crc <= crc_adv;
      len <= len >> 1;
    end
  end

  // zero length passes the first CRC through untouched
  assign crc_joined = len_zero ? crc : (crc ^ crc2);

endmodule

@@ rtl/core/crc32c_combine.sv @@
// ----------------------------------------------------------------------------
// crc32c_combine
// Result: strobed on done once the run state has stepped through every length bit.
// A new start is not taken while busy; it is taken while done is high.
// Each transfer makes one pass per length bit through the shared matrix unit.
// Reset (rst, synchronous, active high) returns the sequencer to idle.
// The receiver cannot stall: crc_joined is valid only in the done cycle.
// ----------------------------------------------------------------------------
`include "crc32c_combine_macros.svh"

module crc32c_combine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  output logic                             done,
  input  logic [crc32c_pkg::CrcW-1:0]      crc_first,
  input  logic [crc32c_pkg::CrcW-1:0]      crc_second,
  input  logic [crc32c_pkg::LenBits-1:0]   second_length,
  output logic [crc32c_pkg::CrcW-1:0]      crc_joined
);

  // Command bus from sequencer to datapath: load on the input transfer,
  // then one step per length bit, indexing the 2^k zero-byte operator.
  crc32c_pkg::dp_cmd_t cmd;

  crc32c_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Datapath holds the running CRC, second CRC and the shifting length;
  // the result is formed from the two CRC registers and a zero-length flag in the done cycle.
  crc32c_dpath u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .crc_first     (crc_first),
    .crc_second    (crc_second),
    .second_length (second_length),
    .crc_joined    (crc_joined)
  );

  // An accepted transfer always starts the step sequence.
  `CRC32C_ASSERT(a_start_busy, clk, rst, (start && !busy) |=> busy, "start not taken")
  // A result strobe only follows the last step cycle.
  `CRC32C_ASSERT(a_done_after_run, clk, rst, done |-> $past(busy), "stray done")
  // Strobe and busy are never both up.
  `CRC32C_NEVER(a_done_busy, clk, rst, done && busy, "done while busy")
  // Steps only run while busy; loads only while not busy.
  `CRC32C_NEVER(a_cmd_ok, clk, rst, (cmd.step && !busy) || (cmd.load && busy), "bad command")

endmodule

@@ dv/crc32c_combine_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc32c_combine_test
// Self-checking bench for the CRC-32C combine block. A short table of
// directed cases is followed by about 500 random combines. Start transfers
// come with random gaps. Each done strobe is checked against a known answer
// or a local GF(2) matrix model of the zero-byte advance, in transfer order.
// ----------------------------------------------------------------------------
module crc32c_combine_test;

  localparam int unsigned CRC_W          = crc32c_pkg::CrcW;
  localparam int unsigned LEN_W          = crc32c_pkg::LenBits;
  localparam logic [31:0] CASTAGNOLI     = 32'h82F6_3B78;
  localparam int          RANDOM_ITEMS   = 500;
  // Watchdog bound on cycles with neither a done nor an accepted start.
  localparam int          WATCHDOG_LIMIT = 2000;
  // Drain time after the last result.
  localparam int          TAIL_CYCLES    = 40;

  // Column b holds the image of CRC bit b.
  typedef logic [CRC_W-1:0][CRC_W-1:0] gf_mat_t;

  // One row of directed stimulus. typed = 1 means crc is the known answer;
  // otherwise the row is checked against the matrix model.
  typedef struct packed {
    logic [CRC_W-1:0] first;
    logic [CRC_W-1:0] second;
    logic [LEN_W-1:0] len;
    logic             typed;
    logic [CRC_W-1:0] crc;
  } combine_row_t;

  localparam int NUM_ROWS = 18;
  localparam combine_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // zero length: first CRC passes through, second is dropped
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{32'h1234_5678, 32'hDEAD_BEEF, 32'h0000_0000, 1'b1, 32'h1234_5678},
    // first CRC zero: advance of zero is zero, so the second comes out
    '{32'h0000_0000, 32'hA5A5_A5A5, 32'h0000_0001, 1'b1, 32'hA5A5_A5A5},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0000, 32'h5A5A_5A5A, 32'h8000_0000, 1'b1, 32'h5A5A_5A5A},
    // everything else goes through the model
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
    '{32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
    '{32'h8000_0000, 32'h0000_0000, 32'h0000_0002, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0},
    '{32'hE306_9283, 32'h0000_0000, 32'h0000_0004, 1'b0, 32'h0},
    '{32'hE306_9283, 32'hE306_9283, 32'h0000_0009, 1'b0, 32'h0},
    '{32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0001_0000, 1'b0, 32'h0},
    '{32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h5555_5555, 1'b0, 32'h0},
    '{32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'hAAAA_AAAA, 1'b0, 32'h0},
    '{32'h1357_9BDF, 32'h2468_ACE0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0100, 1'b0, 32'h0}
  };

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             done;
  logic [CRC_W-1:0] crc_first;
  logic [CRC_W-1:0] crc_second;
  logic [LEN_W-1:0] second_length;
  logic [CRC_W-1:0] crc_joined;

  // Known answer riding along with the current start, if any.
  logic             row_typed;
  logic [CRC_W-1:0] row_crc;

  logic [CRC_W-1:0] pending_crc[$];
  gf_mat_t          zero_byte_ops [LEN_W];  // operator for 2^k zero bytes
  int               error_count;
  int               quiet_cycles;
  bit               burst_mode;

  crc32c_combine u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .crc_first     (crc_first),
    .crc_second    (crc_second),
    .second_length (second_length),
    .crc_joined    (crc_joined)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // GF(2) matrix model of the zero-byte advance
  // ---------------------------------------------------------------------------
  function automatic logic [CRC_W-1:0] gf_mul_vec(gf_mat_t m, logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] acc;
    acc = '0;
    for (int b = 0; b < CRC_W; b++) begin
      if (v[b]) acc ^= m[b];
    end
    return acc;
  endfunction

  function automatic gf_mat_t gf_sqr(gf_mat_t m);
    gf_mat_t t;
    for (int b = 0; b < CRC_W; b++) begin
      t[b] = gf_mul_vec(m, m[b]);
    end
    return t;
  endfunction

  // Shift-by-one-zero-bit operator, squared up to one byte, then one entry
  // per power of two bytes.
  task automatic build_zero_byte_ops();
    gf_mat_t op;
    op[0] = CASTAGNOLI;
    for (int k = 1; k < CRC_W; k++) begin
      op[k] = 32'h1 << (k - 1);
    end
    repeat (3) op = gf_sqr(op);
    for (int k = 0; k < LEN_W; k++) begin
      zero_byte_ops[k] = op;
      op = gf_sqr(op);
    end
  endtask

  // CRC of first||second given both CRCs and the length of second.
  function automatic logic [CRC_W-1:0] joined_crc(logic [CRC_W-1:0] first,
                                                 logic [CRC_W-1:0] second,
                                                 logic [LEN_W-1:0] len);
    logic [CRC_W-1:0] acc;
    if (len == '0) return first;  // zero length: second CRC is not used
    acc = first;
    for (int k = 0; k < LEN_W; k++) begin
      if (len[k]) acc = gf_mul_vec(zero_byte_ops[k], acc);
    end
    return acc ^ second;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one; none at all in burst mode.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode) return 0;
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  // start stays high straight into the next item when there is no gap.
  task automatic send_combine(logic [CRC_W-1:0] first, logic [CRC_W-1:0] second,
                              logic [LEN_W-1:0] len, logic typed,
                              logic [CRC_W-1:0] crc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    crc_first     = first;
    crc_second    = second;
    second_length = len;
    row_typed     = typed;
    row_crc       = crc;
    start         = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  function automatic logic [CRC_W-1:0] random_crc();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Length mix: some zero, some short blocks, some single powers of two,
  // some in the top half of the range and some fully random.
  function automatic logic [LEN_W-1:0] random_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return $urandom_range(1, 300);
      4, 5:    return 32'h1 << $urandom_range(0, LEN_W - 1);
      6:       return $urandom() | 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    crc_first     = '0;
    crc_second    = '0;
    second_length = '0;
    row_typed     = 1'b0;
    row_crc       = '0;
    error_count   = 0;
    quiet_cycles  = 0;
    burst_mode    = 1'b0;
    clk           = 1'b0;
    build_zero_byte_ops();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_combine(DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].second,
                   DIRECTED_ROWS[i].len, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].crc);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // back-to-back stretches now and then
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_combine(random_crc(), random_crc(), random_length(), 1'b0, '0);
    end
    start = 1'b0;

    while (pending_crc.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("crc32c_combine_test: clean");
    end else begin
      $display("crc32c_combine_test: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard and watchdog, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_and_track
    logic [CRC_W-1:0] want;
    logic [CRC_W-1:0] queued;
    if (!rst) begin
      // a done in the same cycle as a new start belongs to the older item,
      // so pop before queueing the new one
      if (done) begin
        if (pending_crc.size() == 0) begin
          $error("crc_joined: result 0x%08h with no transfer outstanding", crc_joined);
          error_count++;
        end else begin
          want = pending_crc.pop_front();
          if (crc_joined !== want) begin
            $error("crc_joined: expected 0x%08h, actual 0x%08h", want, crc_joined);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        queued = row_typed ? row_crc
                           : joined_crc(crc_first, crc_second, second_length);
        pending_crc = {pending_crc, queued};
      end
      if (done || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("crc32c_combine_test: errors");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/crc32c_pkg.sv
rtl/core/crc32c_ctrl.sv
rtl/core/crc32c_dpath.sv
rtl/core/crc32c_combine.sv
dv/crc32c_combine_test.sv
